/* hdl/cpq_pkg.sv */
`default_nettype none

package cpq_pkg;

   // strip geometry
   localparam int SLOTS   = 32;
   localparam int STRIP_W = 2 * SLOTS;

   // counter width and saturation value
   localparam int          CNT_W = 16;
   localparam logic [15:0] SAT16 = 16'hFFFF;

   // configuration port
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE = 2'd0,
      CSR_WARN      = 2'd1,
      CSR_HOLDOFF   = 2'd2,
      CSR_SLOT      = 2'd3
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [15:0] MIN_PULSE_RST = 16'd2;
   localparam logic [15:0] WARN_RST      = 16'd20;
   localparam logic [15:0] HOLDOFF_RST   = 16'd10;
   localparam logic [15:0] SLOT_RST      = 16'd100;

   // tier codes
   localparam logic [1:0] TIER_NONE = 2'd0;
   localparam logic [1:0] TIER_INFO = 2'd1;
   localparam logic [1:0] TIER_WARN = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] min_pulse_ticks;
      logic [CNT_W-1:0] warn_ticks;
      logic [CNT_W-1:0] holdoff_ticks;
      logic [CNT_W-1:0] slot_len;
   } cfg_type;

   typedef struct packed {
      logic               raw_level;
      logic [CNT_W-1:0]   edge_total;
      logic               present;
      logic [1:0]         level_now;
      logic [CNT_W-1:0]   detect_total;
      logic               event_valid;
      logic [CNT_W-1:0]   event_length;
      logic [1:0]         event_level;
      logic [STRIP_W-1:0] strip;
   } rsp_type;

   // saturating increment of a 16-bit tick count
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == SAT16) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

/* hdl/carrier_presence_qualifier.sv */
// output: a result word is on the rsp_ outputs in the cycle after its sample is accepted
// throughput: one sample per cycle; req_ready drops only while the output register
//    holds a word that rsp_ready is not taking
// reset: synchronous, active high; clears all tracking state, counters and the strip,
//    empties the output register and loads the configuration defaults
`default_nettype none

module carrier_presence_qualifier
   import cpq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_field_raw,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_raw_level,
   output logic [CNT_W-1:0]          rsp_edge_total,
   output logic                      rsp_present,
   output logic [1:0]                rsp_level_now,
   output logic [CNT_W-1:0]          rsp_detect_total,
   output logic                      rsp_event_valid,
   output logic [CNT_W-1:0]          rsp_event_length,
   output logic [1:0]                rsp_event_level,
   output logic [STRIP_W-1:0]        rsp_strip,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]     csr_wdata
);

   cfg_type cfg_ff;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   logic    rsp_valid_ff;
   logic    req_fire;

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_ticks <= MIN_PULSE_RST;
         cfg_ff.warn_ticks      <= WARN_RST;
         cfg_ff.holdoff_ticks   <= HOLDOFF_RST;
         cfg_ff.slot_len        <= SLOT_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_PULSE: cfg_ff.min_pulse_ticks <= csr_wdata;
            CSR_WARN:      cfg_ff.warn_ticks      <= csr_wdata;
            CSR_HOLDOFF:   cfg_ff.holdoff_ticks   <= csr_wdata;
            CSR_SLOT:      cfg_ff.slot_len        <= csr_wdata;
            default: ;
         endcase
      end
   end

   cpq_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .field_raw (req_field_raw),
      .cfg       (cfg_ff),
      .result    (core_rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_level    = rsp_ff.raw_level;
   assign rsp_edge_total   = rsp_ff.edge_total;
   assign rsp_present      = rsp_ff.present;
   assign rsp_level_now    = rsp_ff.level_now;
   assign rsp_detect_total = rsp_ff.detect_total;
   assign rsp_event_valid  = rsp_ff.event_valid;
   assign rsp_event_length = rsp_ff.event_length;
   assign rsp_event_level  = rsp_ff.event_level;
   assign rsp_strip        = rsp_ff.strip;

   // an accepted sample always shows up as a word
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted sample produced no word");
   // an ending detection reports a tier and is no longer present
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_valid) |->
         (!rsp_ff.present && (rsp_ff.event_level == TIER_INFO ||
                              rsp_ff.event_level == TIER_WARN)))
      else $error("bad event word");
   // present and tier agree in every word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.present == (rsp_ff.level_now != TIER_NONE)))
      else $error("present and tier disagree");

endmodule

`default_nettype wire

/* hdl/cpq_core.sv */
`default_nettype none

module cpq_core
   import cpq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire logic    field_raw,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic               prev_ff, prev_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic               latched_ff, latched_in;
   logic [1:0]         tier_ff, tier_in;
   logic [CNT_W-1:0]   since_latch_ff, since_latch_in;
   logic [CNT_W-1:0]   since_high_ff, since_high_in;
   logic [CNT_W-1:0]   len_high_ff, len_high_in;
   logic [CNT_W-1:0]   edges_ff, edges_in;
   logic [CNT_W-1:0]   detect_ff, detect_in;
   logic [CNT_W-1:0]   slot_timer_ff, slot_timer_in;
   logic [STRIP_W-1:0] hist_ff, hist_in;

   logic [CNT_W-1:0]   timer_inc;
   logic [1:0]         mark_val;
   logic               ev_valid;
   logic [CNT_W-1:0]   ev_length;
   logic [1:0]         ev_level;

   // next state for one sample
   always_comb begin
      prev_in        = prev_ff;
      run_in         = run_ff;
      latched_in     = latched_ff;
      tier_in        = tier_ff;
      since_latch_in = since_latch_ff;
      len_high_in    = len_high_ff;
      edges_in       = edges_ff;
      detect_in      = detect_ff;
      slot_timer_in  = slot_timer_ff;
      hist_in        = hist_ff;
      timer_inc      = slot_timer_ff + 16'd1;
      mark_val       = TIER_NONE;
      ev_valid       = 1'b0;
      ev_length      = '0;
      ev_level       = TIER_NONE;

      // strip scroll at slot boundary, zero slot length holds the strip
      if (cfg.slot_len != '0) begin
         if (timer_inc >= cfg.slot_len) begin
            hist_in       = hist_ff >> 2;
            slot_timer_in = '0;
         end else begin
            slot_timer_in = timer_inc;
         end
      end

      // edge and run tracking
      if (field_raw != prev_ff) begin
         prev_in  = field_raw;
         edges_in = edges_ff + 16'd1;
         run_in   = '0;
      end else begin
         run_in = sat_inc(run_ff);
      end
      since_high_in = field_raw ? '0 : sat_inc(since_high_ff);

      // latch, or promote and release
      if (!latched_ff) begin
         if (field_raw && (run_in >= cfg.min_pulse_ticks)) begin
            latched_in     = 1'b1;
            since_latch_in = '0;
            len_high_in    = '0;
            tier_in        = TIER_INFO;
            detect_in      = detect_ff + 16'd1;
            mark_val       = TIER_INFO;
         end
      end else begin
         since_latch_in = sat_inc(since_latch_ff);
         if (field_raw) begin
            len_high_in = since_latch_in;
         end
         if ((tier_ff == TIER_INFO) && (since_latch_in >= cfg.warn_ticks)) begin
            tier_in  = TIER_WARN;
            mark_val = TIER_WARN;
         end
         if (!field_raw && (since_high_in >= cfg.holdoff_ticks)) begin
            latched_in = 1'b0;
            ev_valid   = 1'b1;
            ev_length  = len_high_ff;
            ev_level   = tier_in;
            tier_in    = TIER_NONE;
         end
      end

      // mark the newest slot with the highest tier
      if (mark_val > hist_in[STRIP_W-1 -: 2]) begin
         hist_in[STRIP_W-1 -: 2] = mark_val;
      end
   end

   // result word for this sample
   always_comb begin
      result.raw_level    = prev_in;
      result.edge_total   = edges_in;
      result.present      = latched_in;
      result.level_now    = tier_in;
      result.detect_total = detect_in;
      result.event_valid  = ev_valid;
      result.event_length = ev_length;
      result.event_level  = ev_level;
      result.strip        = hist_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= 1'b0;
         run_ff         <= '0;
         latched_ff     <= 1'b0;
         tier_ff        <= TIER_NONE;
         since_latch_ff <= '0;
         since_high_ff  <= '0;
         len_high_ff    <= '0;
         edges_ff       <= '0;
         detect_ff      <= '0;
         slot_timer_ff  <= '0;
         hist_ff        <= '0;
      end else if (fire) begin
         prev_ff        <= prev_in;
         run_ff         <= run_in;
         latched_ff     <= latched_in;
         tier_ff        <= tier_in;
         since_latch_ff <= since_latch_in;
         since_high_ff  <= since_high_in;
         len_high_ff    <= len_high_in;
         edges_ff       <= edges_in;
         detect_ff      <= detect_in;
         slot_timer_ff  <= slot_timer_in;
         hist_ff        <= hist_in;
      end
   end

   // a latched detection always carries a tier, a released one none
   assert property (@(posedge clock) disable iff (reset)
      latched_ff |-> (tier_ff == TIER_INFO || tier_ff == TIER_WARN))
      else $error("latched detection without tier");
   assert property (@(posedge clock) disable iff (reset)
      !latched_ff |-> (tier_ff == TIER_NONE))
      else $error("tier set while released");
   assert property (@(posedge clock) disable iff (reset)
      (fire && ev_valid) |=> !latched_ff)
      else $error("event without release");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import cpq_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int BURST_ITEMS = 150;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // block ports
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_field_raw = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_raw_level;
   logic [CNT_W-1:0]     rsp_edge_total;
   logic                 rsp_present;
   logic [1:0]           rsp_level_now;
   logic [CNT_W-1:0]     rsp_detect_total;
   logic                 rsp_event_valid;
   logic [CNT_W-1:0]     rsp_event_length;
   logic [1:0]           rsp_event_level;
   logic [STRIP_W-1:0]   rsp_strip;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_MIN_PULSE;
   logic [CNT_W-1:0]     csr_wdata = '0;

   carrier_presence_qualifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_field_raw    (req_field_raw),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_raw_level    (rsp_raw_level),
      .rsp_edge_total   (rsp_edge_total),
      .rsp_present      (rsp_present),
      .rsp_level_now    (rsp_level_now),
      .rsp_detect_total (rsp_detect_total),
      .rsp_event_valid  (rsp_event_valid),
      .rsp_event_length (rsp_event_length),
      .rsp_event_level  (rsp_event_level),
      .rsp_strip        (rsp_strip),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // tracker state mirrored from the block
   cfg_type          cfg_copy = '{MIN_PULSE_RST, WARN_RST, HOLDOFF_RST, SLOT_RST};
   logic             level_q = 1'b0;
   logic [CNT_W-1:0] run_len = '0;
   logic             holding = 1'b0;
   logic [1:0]       tier = TIER_NONE;
   logic [CNT_W-1:0] since_lat = '0;
   logic [CNT_W-1:0] since_hi = '0;
   logic [CNT_W-1:0] hold_len = '0;
   logic [CNT_W-1:0] edge_cnt = '0;
   logic [CNT_W-1:0] detect_cnt = '0;
   logic [CNT_W-1:0] slot_count = '0;
   logic [1:0]       tier_hist [SLOTS] = '{default: TIER_NONE};

   logic    sample_queue[$];
   rsp_type status_due[$];
   int      error_count = 0;
   int      stall_cycles = 0;
   bit      calm = 1'b0;

   // tick count that sticks at the top
   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (v == SAT16) ? v : v + 1'b1;
   endfunction

   // raise the newest slot of the strip to a tier
   function automatic void mark_slot(input logic [1:0] t);
      if (t > tier_hist[SLOTS-1]) begin
         tier_hist[SLOTS-1] = t;
      end
   endfunction

   // one tick of the qualifier: returns the status word it produces
   function automatic rsp_type qualify_sample(input logic raw);
      rsp_type r;
      r = '0;

      // strip scroll at slot boundary, zero slot length never scrolls
      if (cfg_copy.slot_len != '0) begin
         slot_count = slot_count + 1'b1;
         if (slot_count >= cfg_copy.slot_len) begin
            for (int i = 0; i < SLOTS - 1; i++) tier_hist[i] = tier_hist[i+1];
            tier_hist[SLOTS-1] = TIER_NONE;
            slot_count = '0;
         end
      end

      // edges and run length
      if (raw != level_q) begin
         level_q = raw;
         edge_cnt = edge_cnt + 1'b1;
         run_len = '0;
      end else begin
         run_len = bump(run_len);
      end
      since_hi = raw ? '0 : bump(since_hi);

      // latch, or promote then release
      if (!holding) begin
         if (raw && run_len >= cfg_copy.min_pulse_ticks) begin
            holding = 1'b1;
            since_lat = '0;
            hold_len = '0;
            tier = TIER_INFO;
            detect_cnt = detect_cnt + 1'b1;
            mark_slot(TIER_INFO);
         end
      end else begin
         since_lat = bump(since_lat);
         if (raw) begin
            hold_len = since_lat;
         end
         if (tier == TIER_INFO && since_lat >= cfg_copy.warn_ticks) begin
            tier = TIER_WARN;
            mark_slot(TIER_WARN);
         end
         if (!raw && since_hi >= cfg_copy.holdoff_ticks) begin
            holding = 1'b0;
            r.event_valid = 1'b1;
            r.event_length = hold_len;
            r.event_level = tier;
            tier = TIER_NONE;
         end
      end

      r.raw_level = level_q;
      r.edge_total = edge_cnt;
      r.present = holding;
      r.level_now = tier;
      r.detect_total = detect_cnt;
      for (int i = 0; i < SLOTS; i++) r.strip[2*i +: 2] = tier_hist[i];
      return r;
   endfunction

   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 18);
   endfunction

   task automatic report(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         report($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            status_due.push_back(qualify_sample(req_field_raw));
         end
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && !take_break()) begin
               req_valid <= 1'b1;
               req_field_raw <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // status word monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               report("status word with nothing expected");
            end else begin
               want = status_due.pop_front();
               check_field("raw_level", 64'(want.raw_level), 64'(rsp_raw_level));
               check_field("edge_total", 64'(want.edge_total), 64'(rsp_edge_total));
               check_field("present", 64'(want.present), 64'(rsp_present));
               check_field("level_now", 64'(want.level_now), 64'(rsp_level_now));
               check_field("detect_total", 64'(want.detect_total),
                           64'(rsp_detect_total));
               check_field("event_valid", 64'(want.event_valid), 64'(rsp_event_valid));
               check_field("event_length", 64'(want.event_length),
                           64'(rsp_event_length));
               check_field("event_level", 64'(want.event_level), 64'(rsp_event_level));
               check_field("strip", want.strip, rsp_strip);
            end
         end
         rsp_ready <= !take_break();
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // block is idle once every queued sample has its status word back
   task automatic wait_idle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || status_due.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CNT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_PULSE: cfg_copy.min_pulse_ticks = val;
         CSR_WARN:      cfg_copy.warn_ticks = val;
         CSR_HOLDOFF:   cfg_copy.holdoff_ticks = val;
         CSR_SLOT:      cfg_copy.slot_len = val;
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [CNT_W-1:0] min_pulse, input logic [CNT_W-1:0] warn,
                               input logic [CNT_W-1:0] holdoff, input logic [CNT_W-1:0] slot);
      write_reg(CSR_MIN_PULSE, min_pulse);
      write_reg(CSR_WARN, warn);
      write_reg(CSR_HOLDOFF, holdoff);
      write_reg(CSR_SLOT, slot);
   endtask

   task automatic queue_pattern(input string bits);
      for (int i = 0; i < bits.len(); i++) sample_queue.push_back(bits.getc(i) == "1");
   endtask

   // alternating high and low bursts sized around the current thresholds, some glitches
   task automatic queue_bursts(input int count);
      int   n;
      int   len;
      logic lvl;
      n = 0;
      lvl = 1'($urandom_range(0, 1));
      while (n < count) begin
         if ($urandom_range(0, 99) < 15) begin
            len = 1;
         end else if (lvl) begin
            len = $urandom_range(1, int'(cfg_copy.min_pulse_ticks) +
                                    int'(cfg_copy.warn_ticks) + 8);
         end else begin
            len = $urandom_range(1, 2 * int'(cfg_copy.holdoff_ticks) + 4);
         end
         if (len > count - n) begin
            len = count - n;
         end
         repeat (len) sample_queue.push_back(lvl);
         n += len;
         lvl = !lvl;
      end
   endtask

   // stimulus phases
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: glitch, latch, short gap, release after holdoff
      queue_pattern("101111101000000000011000");
      wait_idle();

      // zero thresholds and a strip that never scrolls
      program_regs('0, '0, '0, '0);
      queue_pattern("1101100111010001");
      wait_idle();

      // long runs with no idling on either side: promote, release, fast strip
      calm = 1'b1;
      program_regs('0, 16'd40, 16'd30, 16'd7);
      repeat (160) sample_queue.push_back(1'b1);
      repeat (98) sample_queue.push_back(1'b0);
      queue_pattern("11");
      wait_idle();
      calm = 1'b0;

      // mixed extremes, fastest strip
      program_regs(SAT16, '0, '0, 16'd1);
      queue_bursts(BURST_ITEMS);
      wait_idle();

      // small thresholds where most of the behavior lives
      for (int p = 0; p < 5; p++) begin
         program_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 30)),
                      16'($urandom_range(0, 12)), 16'($urandom_range(1, 20)));
         queue_bursts(BURST_ITEMS);
         wait_idle();
      end

      // full-range register values
      program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      queue_bursts(BURST_ITEMS);
      wait_idle();

      repeat (4) @(posedge clock);
      if (error_count == 0 && status_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/cpq_pkg.sv
hdl/cpq_core.sv
hdl/carrier_presence_qualifier.sv
tb/testbench.sv
